FILE: sv/clp_pkg.sv
// Shared types, codes and constants of the colormap palette block.
package clp_pkg;

   localparam logic [2:0] MODE_WR_LUT = 3'd0;
   localparam logic [2:0] MODE_RD_LUT = 3'd1;
   localparam logic [2:0] MODE_WR_OFM = 3'd2;
   localparam logic [2:0] MODE_RD_OFM = 3'd3;
   localparam logic [2:0] MODE_WR_GFX = 3'd4;
   localparam logic [2:0] MODE_RD_GFX = 3'd5;
   localparam logic [2:0] MODE_SELECT = 3'd6;
   localparam logic [2:0] MODE_PIXEL  = 3'd7;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHANNEL = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX   = 2'd2;

   localparam int GRAPHICS_PLANES = 4;
   localparam int GRAPHICS_WORDS  = 5;
   localparam int OVERLAY_SLOTS   = 16;
   localparam int COLOR_SHIFT     = 8;
   localparam int COLOURS         = 3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] colour_mask;
      logic [2:0] channel;
      logic [7:0] index;
      logic [7:0] value;
      logic [7:0] grfx_green;
      logic [7:0] grfx_blue;
   } clp_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  read_value;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } clp_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  mode;
      logic [1:0]  status;
      logic [2:0]  colour_mask;
      logic [7:0]  index;
      logic [7:0]  value;
      logic        image_pixel;
      logic [7:0]  read_value;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } clp_stage_type;

   // blue wins over green, green over red
   function automatic logic [7:0] pick_colour(input logic [2:0] mask,
                                              input logic [2:0][7:0] data);
      logic [7:0] result;
      result = 8'd0;
      if (mask[0]) result = data[0];
      if (mask[1]) result = data[1];
      if (mask[2]) result = data[2];
      return result;
   endfunction

endpackage

FILE: sv/clp_req_if.sv
// Request channel of the colormap palette block.
interface clp_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [2:0] colour_mask;
   logic [2:0] channel;
   logic [7:0] index;
   logic [7:0] value;
   logic [7:0] grfx_green;
   logic [7:0] grfx_blue;

   modport source (output valid, mode, colour_mask, channel, index, value, grfx_green,
                   grfx_blue, input ready);
   modport sink (input valid, mode, colour_mask, channel, index, value, grfx_green,
                 grfx_blue, output ready);
endinterface

FILE: sv/clp_rsp_if.sv
// Response channel of the colormap palette block.
interface clp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  read_value;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;

   modport source (output valid, status, read_value, red, green, blue, input ready);
   modport sink (input valid, status, read_value, red, green, blue, output ready);
endinterface

FILE: sv/colormap_lut_palette_core.sv
// Top level of the colormap palette: two-level colour LUT with graphics overlay.
//
// Requests arrive on req_ch (valid/ready); each transfer carries one access chosen
// by mode: LUT, OFM or graphics word write/read, grey channel select, or a pixel
// lookup. Every accepted request gives exactly one response on rsp_ch, in order.
// From the request transfer to a valid response, a request passes the LUT
// memory read, then the OFM memory read that it addresses, then the response
// queue. Throughput is one request per cycle while rsp_ch takes each response;
// the two memory reads in series are pipelined, so pixel lookups stream at the
// clock rate. Writes land in each memory at the same stage as its reads, so
// back-to-back accesses to the same entry need no forwarding.
// Reset clears the selected channel (image off), the graphics and cursor words,
// the pipeline and the response queue. LUT and OFM contents are undefined until
// written; there is no clearing pass.
// When rsp_ch stalls, a 4-entry queue absorbs the results in flight; req_ch.ready
// drops while four requests are in flight and not yet taken.
module colormap_lut_palette_core #(
   parameter int GREY_CHANNELS = 4,
   parameter int IMAGE_LEVELS  = 240,
   parameter int INTENSITIES   = 256
) (
   input  logic         clock,
   input  logic         reset,
   clp_req_if.sink      req_ch,
   clp_rsp_if.source    rsp_ch
);
   clp_pkg::clp_req_type              req;
   clp_pkg::clp_stage_type            lut_stage;
   logic [2:0][7:0]                   lut_data;
   logic                              ofm_valid;
   clp_pkg::clp_rsp_type              ofm_rsp;
   clp_pkg::clp_rsp_type              fifo_rsp;
   logic                              fifo_valid;
   logic [clp_pkg::FIFO_CW-1:0]       fifo_count;
   logic [clp_pkg::FIFO_CW-1:0]       in_flight;
   logic                              accept;

   assign req.mode        = req_ch.mode;
   assign req.colour_mask = req_ch.colour_mask;
   assign req.channel     = req_ch.channel;
   assign req.index       = req_ch.index;
   assign req.value       = req_ch.value;
   assign req.grfx_green  = req_ch.grfx_green;
   assign req.grfx_blue   = req_ch.grfx_blue;

   assign in_flight = fifo_count + clp_pkg::FIFO_CW'(lut_stage.valid)
                      + clp_pkg::FIFO_CW'(ofm_valid);
   assign req_ch.ready = (in_flight < clp_pkg::FIFO_CW'(clp_pkg::FIFO_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   clp_lut_stage #(
      .GREY_CHANNELS (GREY_CHANNELS),
      .IMAGE_LEVELS  (IMAGE_LEVELS),
      .INTENSITIES   (INTENSITIES)
   ) u_lut_stage (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .lut_stage (lut_stage),
      .lut_data  (lut_data)
   );

   clp_ofm_stage #(
      .INTENSITIES (INTENSITIES)
   ) u_ofm_stage (
      .clock     (clock),
      .reset     (reset),
      .lut_stage (lut_stage),
      .lut_data  (lut_data),
      .rsp_valid (ofm_valid),
      .rsp_data  (ofm_rsp)
   );

   clp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ofm_valid),
      .push_data (ofm_rsp),
      .out_ready (rsp_ch.ready),
      .out_valid (fifo_valid),
      .out_data  (fifo_rsp),
      .count     (fifo_count)
   );

   assign rsp_ch.valid      = fifo_valid;
   assign rsp_ch.status     = fifo_rsp.status;
   assign rsp_ch.read_value = fifo_rsp.read_value;
   assign rsp_ch.red        = fifo_rsp.red;
   assign rsp_ch.green      = fifo_rsp.green;
   assign rsp_ch.blue       = fifo_rsp.blue;

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      ofm_valid |-> fifo_count < clp_pkg::FIFO_CW'(clp_pkg::FIFO_DEPTH))
      else $error("response queue full while a result arrives");

   a_enter_pipe: assert property (@(posedge clock) disable iff (reset)
      accept |=> lut_stage.valid)
      else $error("accepted request missing from LUT stage");

   a_advance_pipe: assert property (@(posedge clock) disable iff (reset)
      lut_stage.valid |=> ofm_valid)
      else $error("request dropped between LUT and OFM stages");

   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight <= clp_pkg::FIFO_CW'(clp_pkg::FIFO_DEPTH))
      else $error("more requests in flight than queue entries");

endmodule

FILE: sv/clp_lut_stage.sv
// Decode stage: request checks, channel and graphics registers, grey-channel LUT memories.
module clp_lut_stage #(
   parameter int GREY_CHANNELS = 4,
   parameter int IMAGE_LEVELS  = 240,
   parameter int INTENSITIES   = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  clp_pkg::clp_req_type       req,
   output clp_pkg::clp_stage_type     lut_stage,
   output logic [2:0][7:0]            lut_data
);
   localparam int LUT_DEPTH   = GREY_CHANNELS * IMAGE_LEVELS;
   localparam int LUT_AW      = $clog2(LUT_DEPTH);
   localparam int OVERLAY_END = IMAGE_LEVELS + clp_pkg::OVERLAY_SLOTS;

   logic [2:0]                                   channel_ff, channel_in;
   logic [clp_pkg::GRAPHICS_WORDS-1:0][23:0]     words_ff, words_in;
   clp_pkg::clp_stage_type                       stage_ff, stage_in;
   logic [1:0]                                   status;
   logic [2:0]                                   lut_channel;
   logic [2:0]                                   lut_channel_m1;
   logic [LUT_AW-1:0]                            lut_addr;
   logic [3:0]                                   slot;
   logic [3:0]                                   planes;
   logic [23:0]                                  overlay;
   logic [23:0]                                  word_rd;
   logic [2:0]                                   lut_we;
   logic                                         ok;

   always_comb begin
      status = clp_pkg::STATUS_OK;
      case (req.mode)
         clp_pkg::MODE_WR_LUT, clp_pkg::MODE_RD_LUT: begin
            if (req.channel == 3'd0 || req.channel > 3'(GREY_CHANNELS)) begin
               status = clp_pkg::STATUS_BAD_CHANNEL;
            end else if (req.index >= 8'(IMAGE_LEVELS)) begin
               status = clp_pkg::STATUS_BAD_INDEX;
            end
         end
         clp_pkg::MODE_WR_OFM, clp_pkg::MODE_RD_OFM: begin
            if ({1'b0, req.index} >= 9'(INTENSITIES)) status = clp_pkg::STATUS_BAD_INDEX;
         end
         clp_pkg::MODE_WR_GFX, clp_pkg::MODE_RD_GFX: begin
            if (req.channel > 3'(clp_pkg::GRAPHICS_PLANES)) begin
               status = clp_pkg::STATUS_BAD_CHANNEL;
            end
         end
         clp_pkg::MODE_SELECT: begin
            if (req.channel > 3'(GREY_CHANNELS)) status = clp_pkg::STATUS_BAD_CHANNEL;
         end
         clp_pkg::MODE_PIXEL: begin
            if ({1'b0, req.index} >= 9'(OVERLAY_END)) status = clp_pkg::STATUS_BAD_INDEX;
         end
         default: status = clp_pkg::STATUS_OK;
      endcase
   end

   assign ok = (status == clp_pkg::STATUS_OK);

   // overlay colour: cursor on the last slot, else XOR of planes picked by slot+1
   always_comb begin
      slot    = 4'(req.index - 8'(IMAGE_LEVELS));
      planes  = slot + 4'd1;
      overlay = 24'd0;
      if (slot == 4'hF) begin
         overlay = words_ff[0];
      end else begin
         for (int b = 0; b < 4; b++) begin
            if (planes[b]) overlay = overlay ^ words_ff[b + 1];
         end
      end
   end

   always_comb begin
      word_rd = 24'd0;
      if (req.channel <= 3'(clp_pkg::GRAPHICS_PLANES)) word_rd = words_ff[req.channel];
   end

   always_comb begin
      stage_in             = '0;
      stage_in.valid       = accept;
      stage_in.mode        = req.mode;
      stage_in.status      = status;
      stage_in.colour_mask = req.colour_mask;
      stage_in.index       = req.index;
      stage_in.value       = req.value;
      if (ok) begin
         case (req.mode)
            clp_pkg::MODE_RD_GFX: begin
               stage_in.red   = {8'd0, word_rd[7:0]};
               stage_in.green = {8'd0, word_rd[15:8]};
               stage_in.blue  = {8'd0, word_rd[23:16]};
            end
            clp_pkg::MODE_PIXEL: begin
               if (req.index < 8'(IMAGE_LEVELS)) begin
                  stage_in.image_pixel = (req.index != 8'd0) && (channel_ff != 3'd0);
               end else begin
                  stage_in.red   = 16'(overlay[7:0]) << clp_pkg::COLOR_SHIFT;
                  stage_in.green = 16'(overlay[15:8]) << clp_pkg::COLOR_SHIFT;
                  stage_in.blue  = 16'(overlay[23:16]) << clp_pkg::COLOR_SHIFT;
               end
            end
            default: stage_in.red = 16'd0;
         endcase
      end
   end

   always_comb begin
      channel_in = channel_ff;
      if (accept && ok && req.mode == clp_pkg::MODE_SELECT) channel_in = req.channel;
      words_in = words_ff;
      if (accept && ok && req.mode == clp_pkg::MODE_WR_GFX) begin
         words_in[req.channel] = {req.grfx_blue, req.grfx_green, req.value};
      end
   end

   always_comb begin
      if (req.mode == clp_pkg::MODE_WR_LUT || req.mode == clp_pkg::MODE_RD_LUT) begin
         lut_channel = req.channel;
      end else begin
         lut_channel = channel_ff;
      end
      lut_channel_m1 = lut_channel - 3'd1;
      lut_addr = LUT_AW'(int'(lut_channel_m1) * IMAGE_LEVELS + int'(req.index));
      lut_we   = (accept && ok && req.mode == clp_pkg::MODE_WR_LUT) ? req.colour_mask : 3'b000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= 3'd0;
         words_ff   <= '0;
         stage_ff   <= '0;
      end else begin
         channel_ff <= channel_in;
         words_ff   <= words_in;
         stage_ff   <= stage_in;
      end
   end

   for (genvar c = 0; c < clp_pkg::COLOURS; c++) begin : g_lut
      logic [7:0] lut_mem [LUT_DEPTH];
      logic [7:0] lut_rd_ff;

      always_ff @(posedge clock) begin
         if (lut_we[c]) lut_mem[lut_addr] <= req.value;
         lut_rd_ff <= lut_mem[lut_addr];
      end

      assign lut_data[c] = lut_rd_ff;
   end

   assign lut_stage = stage_ff;

endmodule

FILE: sv/clp_ofm_stage.sv
// Output-function stage: OFM memories and final colour formation.
module clp_ofm_stage #(
   parameter int INTENSITIES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  clp_pkg::clp_stage_type  lut_stage,
   input  logic [2:0][7:0]         lut_data,
   output logic                    rsp_valid,
   output clp_pkg::clp_rsp_type    rsp_data
);
   localparam int OFM_AW = $clog2(INTENSITIES);

   clp_pkg::clp_stage_type      stage_ff, stage_in;
   logic [2:0][OFM_AW-1:0]      ofm_addr;
   logic [2:0]                  ofm_we;
   logic [2:0][7:0]             ofm_data;
   logic                        in_ok;
   logic                        out_ok;

   assign in_ok = (lut_stage.status == clp_pkg::STATUS_OK);

   always_comb begin
      stage_in = lut_stage;
      if (in_ok && lut_stage.mode == clp_pkg::MODE_RD_LUT) begin
         stage_in.read_value = clp_pkg::pick_colour(lut_stage.colour_mask, lut_data);
      end
      for (int c = 0; c < clp_pkg::COLOURS; c++) begin
         if (lut_stage.mode == clp_pkg::MODE_WR_OFM || lut_stage.mode == clp_pkg::MODE_RD_OFM) begin
            ofm_addr[c] = OFM_AW'(lut_stage.index);
         end else begin
            ofm_addr[c] = OFM_AW'(lut_data[c]);
         end
      end
      ofm_we = (lut_stage.valid && in_ok && lut_stage.mode == clp_pkg::MODE_WR_OFM) ?
               lut_stage.colour_mask : 3'b000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   for (genvar c = 0; c < clp_pkg::COLOURS; c++) begin : g_ofm
      logic [7:0] ofm_mem [INTENSITIES];
      logic [7:0] ofm_rd_ff;

      always_ff @(posedge clock) begin
         if (ofm_we[c]) ofm_mem[ofm_addr[c]] <= lut_stage.value;
         ofm_rd_ff <= ofm_mem[ofm_addr[c]];
      end

      assign ofm_data[c] = ofm_rd_ff;
   end

   assign out_ok = (stage_ff.status == clp_pkg::STATUS_OK);

   always_comb begin
      rsp_valid           = stage_ff.valid;
      rsp_data.status     = stage_ff.status;
      rsp_data.read_value = stage_ff.read_value;
      rsp_data.red        = stage_ff.red;
      rsp_data.green      = stage_ff.green;
      rsp_data.blue       = stage_ff.blue;
      if (out_ok && stage_ff.mode == clp_pkg::MODE_RD_OFM) begin
         rsp_data.read_value = clp_pkg::pick_colour(stage_ff.colour_mask, ofm_data);
      end
      if (stage_ff.image_pixel) begin
         rsp_data.red   = 16'(ofm_data[0]) << clp_pkg::COLOR_SHIFT;
         rsp_data.green = 16'(ofm_data[1]) << clp_pkg::COLOR_SHIFT;
         rsp_data.blue  = 16'(ofm_data[2]) << clp_pkg::COLOR_SHIFT;
      end
   end

endmodule

FILE: sv/clp_out_fifo.sv
// Response queue that decouples the lookup pipeline from the receiver.
module clp_out_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  clp_pkg::clp_rsp_type           push_data,
   input  logic                           out_ready,
   output logic                           out_valid,
   output clp_pkg::clp_rsp_type           out_data,
   output logic [clp_pkg::FIFO_CW-1:0]    count
);
   clp_pkg::clp_rsp_type               fifo_mem [clp_pkg::FIFO_DEPTH];
   logic [clp_pkg::FIFO_AW-1:0]        head_ff, head_in;
   logic [clp_pkg::FIFO_AW-1:0]        tail_ff, tail_in;
   logic [clp_pkg::FIFO_CW-1:0]        count_ff, count_in;
   logic                               pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = fifo_mem[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + clp_pkg::FIFO_CW'(push) - clp_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) fifo_mem[tail_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: tb/tb_colormap_lut_palette_core.sv
// Self-checking testbench of the colormap palette core: table accesses, pixel lookups, stalls.
module tb_colormap_lut_palette_core;

   localparam int NUM_GREY    = 4;
   localparam int NUM_LEVELS  = 240;
   localparam int NUM_INTENS  = 256;
   localparam int LUT_ENTRIES = NUM_GREY * NUM_LEVELS;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clp_req_if req_ch();
   clp_rsp_if rsp_ch();

   colormap_lut_palette_core #(
      .GREY_CHANNELS(NUM_GREY),
      .IMAGE_LEVELS(NUM_LEVELS),
      .INTENSITIES(NUM_INTENS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #4 clock = ~clock;

   // palette shadow
   logic [7:0]  lut_mem [clp_pkg::COLOURS][LUT_ENTRIES];
   bit          lut_set [clp_pkg::COLOURS][LUT_ENTRIES];
   logic [7:0]  ofm_mem [clp_pkg::COLOURS][NUM_INTENS];
   bit          ofm_set [clp_pkg::COLOURS][NUM_INTENS];
   logic [23:0] gfx_words [clp_pkg::GRAPHICS_WORDS];
   logic [2:0]  shown_channel;

   clp_pkg::clp_rsp_type pending_colours[$];

   bit idle_on = 1'b1;
   int hold_off_cycles = 0;
   int stall_left = 0;
   int failures = 0;
   int accesses_sent = 0;
   int results_checked = 0;
   int table_pixels = 0;
   int overlay_pixels = 0;

   initial begin
      foreach (gfx_words[i]) gfx_words[i] = '0;
      shown_channel = '0;
   end

   function automatic logic [15:0] shifted(input logic [7:0] level);
      return 16'(level) << clp_pkg::COLOR_SHIFT;
   endfunction

   function automatic clp_pkg::clp_req_type make_access(input logic [2:0] mode,
                                                        input logic [2:0] mask,
                                                        input logic [2:0] channel,
                                                        input logic [7:0] index,
                                                        input logic [7:0] value,
                                                        input logic [7:0] green = 8'd0,
                                                        input logic [7:0] blue = 8'd0);
      clp_pkg::clp_req_type a;
      a.mode        = mode;
      a.colour_mask = mask;
      a.channel     = channel;
      a.index       = index;
      a.value       = value;
      a.grfx_green  = green;
      a.grfx_blue   = blue;
      return a;
   endfunction

   function automatic int lut_addr(input logic [2:0] channel, input logic [7:0] index);
      return (int'(channel) - 1) * NUM_LEVELS + int'(index);
   endfunction

   // true when the access reads no table entry that was never written
   function automatic bit access_defined(input clp_pkg::clp_req_type a);
      int addr;
      if (a.mode == clp_pkg::MODE_RD_LUT && a.channel >= 1 && a.channel <= NUM_GREY
          && a.index < NUM_LEVELS) begin
         addr = lut_addr(a.channel, a.index);
         for (int c = 0; c < clp_pkg::COLOURS; c++)
            if (a.colour_mask[c] && !lut_set[c][addr]) return 1'b0;
      end else if (a.mode == clp_pkg::MODE_RD_OFM && a.index < NUM_INTENS) begin
         for (int c = 0; c < clp_pkg::COLOURS; c++)
            if (a.colour_mask[c] && !ofm_set[c][a.index]) return 1'b0;
      end else if (a.mode == clp_pkg::MODE_PIXEL && a.index != 0 && a.index < NUM_LEVELS
                   && shown_channel >= 1 && shown_channel <= NUM_GREY) begin
         addr = lut_addr(shown_channel, a.index);
         for (int c = 0; c < clp_pkg::COLOURS; c++)
            if (!lut_set[c][addr] || !ofm_set[c][lut_mem[c][addr]]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // apply one access to the shadow palette and return the colour word it gives
   function automatic clp_pkg::clp_rsp_type predict_colour(input clp_pkg::clp_req_type a);
      clp_pkg::clp_rsp_type r;
      int addr;
      int k;
      logic [23:0] w;
      r = '0;
      case (a.mode)
         clp_pkg::MODE_WR_LUT, clp_pkg::MODE_RD_LUT: begin
            if (a.channel == 0 || a.channel > NUM_GREY) begin
               r.status = clp_pkg::STATUS_BAD_CHANNEL;
            end else if (a.index >= NUM_LEVELS) begin
               r.status = clp_pkg::STATUS_BAD_INDEX;
            end else begin
               addr = lut_addr(a.channel, a.index);
               for (int c = 0; c < clp_pkg::COLOURS; c++) begin
                  if (a.colour_mask[c]) begin
                     if (a.mode == clp_pkg::MODE_WR_LUT) begin
                        lut_mem[c][addr] = a.value;
                        lut_set[c][addr] = 1'b1;
                     end else begin
                        r.read_value = lut_mem[c][addr];
                     end
                  end
               end
            end
         end
         clp_pkg::MODE_WR_OFM, clp_pkg::MODE_RD_OFM: begin
            if (a.index >= NUM_INTENS) begin
               r.status = clp_pkg::STATUS_BAD_INDEX;
            end else begin
               for (int c = 0; c < clp_pkg::COLOURS; c++) begin
                  if (a.colour_mask[c]) begin
                     if (a.mode == clp_pkg::MODE_WR_OFM) begin
                        ofm_mem[c][a.index] = a.value;
                        ofm_set[c][a.index] = 1'b1;
                     end else begin
                        r.read_value = ofm_mem[c][a.index];
                     end
                  end
               end
            end
         end
         clp_pkg::MODE_WR_GFX: begin
            if (a.channel > clp_pkg::GRAPHICS_PLANES) r.status = clp_pkg::STATUS_BAD_CHANNEL;
            else gfx_words[a.channel] = {a.grfx_blue, a.grfx_green, a.value};
         end
         clp_pkg::MODE_RD_GFX: begin
            if (a.channel > clp_pkg::GRAPHICS_PLANES) begin
               r.status = clp_pkg::STATUS_BAD_CHANNEL;
            end else begin
               r.red   = 16'(gfx_words[a.channel][7:0]);
               r.green = 16'(gfx_words[a.channel][15:8]);
               r.blue  = 16'(gfx_words[a.channel][23:16]);
            end
         end
         clp_pkg::MODE_SELECT: begin
            if (a.channel > NUM_GREY) r.status = clp_pkg::STATUS_BAD_CHANNEL;
            else shown_channel = a.channel;
         end
         default: begin
            k = int'(a.index) - NUM_LEVELS;
            if (a.index < NUM_LEVELS) begin
               if (a.index != 0 && shown_channel >= 1 && shown_channel <= NUM_GREY) begin
                  addr = lut_addr(shown_channel, a.index);
                  r.red   = shifted(ofm_mem[0][lut_mem[0][addr]]);
                  r.green = shifted(ofm_mem[1][lut_mem[1][addr]]);
                  r.blue  = shifted(ofm_mem[2][lut_mem[2][addr]]);
                  table_pixels++;
               end
            end else if (k < clp_pkg::OVERLAY_SLOTS) begin
               if (k == clp_pkg::OVERLAY_SLOTS - 1) begin
                  w = gfx_words[0];
               end else begin
                  w = '0;
                  for (int b = 0; b < clp_pkg::GRAPHICS_PLANES; b++)
                     if (((k + 1) >> b) & 1) w ^= gfx_words[b + 1];
               end
               r.red   = shifted(w[7:0]);
               r.green = shifted(w[15:8]);
               r.blue  = shifted(w[23:16]);
               overlay_pixels++;
            end else begin
               r.status = clp_pkg::STATUS_BAD_INDEX;
            end
         end
      endcase
      return r;
   endfunction

   function automatic clp_pkg::clp_req_type draw_access();
      clp_pkg::clp_req_type a;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      a.mode = clp_pkg::MODE_PIXEL;
      else if (pick < 62) a.mode = clp_pkg::MODE_WR_LUT;
      else if (pick < 72) a.mode = clp_pkg::MODE_RD_LUT;
      else if (pick < 77) a.mode = clp_pkg::MODE_WR_OFM;
      else if (pick < 84) a.mode = clp_pkg::MODE_RD_OFM;
      else if (pick < 89) a.mode = clp_pkg::MODE_WR_GFX;
      else if (pick < 93) a.mode = clp_pkg::MODE_RD_GFX;
      else                a.mode = clp_pkg::MODE_SELECT;
      a.colour_mask = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
      if ($urandom_range(0, 9) == 0)
         a.channel = 3'($urandom_range(0, 7));
      else if (a.mode == clp_pkg::MODE_WR_GFX || a.mode == clp_pkg::MODE_RD_GFX)
         a.channel = 3'($urandom_range(0, clp_pkg::GRAPHICS_PLANES));
      else
         a.channel = 3'($urandom_range(1, NUM_GREY));
      pick = $urandom_range(0, 9);
      if (pick == 0)
         a.index = 8'($urandom_range(0, 255));
      else if (a.mode == clp_pkg::MODE_PIXEL && pick < 3)
         a.index = 8'($urandom_range(NUM_LEVELS, 255));
      else
         a.index = 8'($urandom_range(0, NUM_LEVELS - 1));
      a.value      = 8'($urandom);
      a.grfx_green = 8'($urandom);
      a.grfx_blue  = 8'($urandom);
      return a;
   endfunction

   // retry until the access is defined, else fill a LUT entry of the shown channel (a random one if none is shown)
   function automatic clp_pkg::clp_req_type next_random_access();
      clp_pkg::clp_req_type a;
      logic [2:0] channel;
      for (int tries = 0; tries < 16; tries++) begin
         a = draw_access();
         if (access_defined(a)) return a;
      end
      channel = (shown_channel >= 1 && shown_channel <= NUM_GREY) ?
                shown_channel : 3'($urandom_range(1, NUM_GREY));
      return make_access(clp_pkg::MODE_WR_LUT, 3'd7, channel,
                         8'($urandom_range(1, NUM_LEVELS - 1)),
                         8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   task automatic send_access(input clp_pkg::clp_req_type a);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.mode, req_ch.colour_mask, req_ch.channel, req_ch.index, req_ch.value,
       req_ch.grfx_green, req_ch.grfx_blue} <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_colours.push_back(predict_colour(a));
      accesses_sent++;
   endtask

   always @(posedge clock) begin
      clp_pkg::clp_rsp_type seen;
      clp_pkg::clp_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen = {rsp_ch.status, rsp_ch.read_value, rsp_ch.red, rsp_ch.green, rsp_ch.blue};
         if (pending_colours.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected transfer: status %0d read %02h rgb %04h %04h %04h",
                        seen.status, seen.read_value, seen.red, seen.green, seen.blue);
         end else begin
            want = pending_colours.pop_front();
            results_checked++;
            if (seen.status !== want.status || seen.read_value !== want.read_value
                || seen.red !== want.red || seen.green !== want.green
                || seen.blue !== want.blue) begin
               failures++;
               if (failures <= 10)
                  $display("result %0d: expected st %0d rd %02h rgb %04h %04h %04h, %s",
                           results_checked, want.status, want.read_value, want.red,
                           want.green, want.blue,
                           $sformatf("got st %0d rd %02h rgb %04h %04h %04h", seen.status,
                                     seen.read_value, seen.red, seen.green, seen.blue));
            end
         end
      end
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic test_reset_state();
      send_access(make_access(clp_pkg::MODE_RD_GFX, 3'd7, 3'd0, 8'd0, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd7, 3'd0, 8'd5, 8'd0));
   endtask

   task automatic test_table_path();
      send_access(make_access(clp_pkg::MODE_WR_OFM, 3'd7, 3'd0, 8'd0, 8'h5a));
      send_access(make_access(clp_pkg::MODE_WR_OFM, 3'd7, 3'd7, 8'd255, 8'hff));
      send_access(make_access(clp_pkg::MODE_WR_LUT, 3'd7, 3'd4, 8'd239, 8'hff));
      send_access(make_access(clp_pkg::MODE_WR_LUT, 3'd1, 3'd4, 8'd1, 8'h00));
      send_access(make_access(clp_pkg::MODE_WR_LUT, 3'd6, 3'd4, 8'd1, 8'h00));
      send_access(make_access(clp_pkg::MODE_RD_LUT, 3'd3, 3'd4, 8'd239, 8'd0));
      send_access(make_access(clp_pkg::MODE_RD_OFM, 3'd5, 3'd0, 8'd255, 8'd0));
      send_access(make_access(clp_pkg::MODE_SELECT, 3'd0, 3'd4, 8'd0, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd7, 3'd0, 8'd239, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd0, 3'd0, 8'd1, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd7, 3'd0, 8'd0, 8'd0));
   endtask

   task automatic test_error_status();
      send_access(make_access(clp_pkg::MODE_WR_LUT, 3'd7, 3'd0, 8'd0, 8'hff));
      send_access(make_access(clp_pkg::MODE_RD_LUT, 3'd7, 3'd5, 8'd239, 8'd0));
      send_access(make_access(clp_pkg::MODE_WR_LUT, 3'd7, 3'd1, 8'd240, 8'hff));
      send_access(make_access(clp_pkg::MODE_RD_LUT, 3'd7, 3'd4, 8'd255, 8'd0));
      send_access(make_access(clp_pkg::MODE_WR_GFX, 3'd7, 3'd5, 8'd0, 8'hff, 8'hff, 8'hff));
      send_access(make_access(clp_pkg::MODE_SELECT, 3'd7, 3'd7, 8'd0, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd7, 3'd0, 8'd239, 8'd0));
   endtask

   task automatic test_empty_mask();
      send_access(make_access(clp_pkg::MODE_WR_LUT, 3'd0, 3'd1, 8'd5, 8'h77));
      send_access(make_access(clp_pkg::MODE_RD_LUT, 3'd0, 3'd1, 8'd5, 8'd0));
      send_access(make_access(clp_pkg::MODE_RD_OFM, 3'd0, 3'd0, 8'd17, 8'd0));
   endtask

   task automatic test_overlay();
      send_access(make_access(clp_pkg::MODE_WR_GFX, 3'd0, 3'd0, 8'd0, 8'ha1, 8'hb2, 8'hc3));
      send_access(make_access(clp_pkg::MODE_WR_GFX, 3'd0, 3'd1, 8'd0, 8'h11, 8'h22, 8'h33));
      send_access(make_access(clp_pkg::MODE_WR_GFX, 3'd0, 3'd4, 8'd0, 8'h44, 8'h55, 8'h66));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd0, 3'd0, 8'd240, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd0, 3'd0, 8'd247, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd0, 3'd0, 8'd254, 8'd0));
      send_access(make_access(clp_pkg::MODE_PIXEL, 3'd0, 3'd0, 8'd255, 8'd0));
      send_access(make_access(clp_pkg::MODE_RD_GFX, 3'd0, 3'd4, 8'd0, 8'd0));
   endtask

   task automatic test_ofm_fill();
      for (int i = 0; i < NUM_INTENS; i++)
         send_access(make_access(clp_pkg::MODE_WR_OFM, 3'd7, 3'($urandom), 8'(i),
                                 8'($urandom)));
   endtask

   // hold the result side so the queue fills and the request side stalls
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_off_cycles = 80;
      repeat (30) send_access(next_random_access());
      idle_on = 1'b1;
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 1000; i++) begin
         if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send_access(next_random_access());
      end
   endtask

   task automatic test_streaming();
      idle_on = 1'b0;
      repeat (150) send_access(next_random_access());
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      {req_ch.mode, req_ch.colour_mask, req_ch.channel, req_ch.index, req_ch.value,
       req_ch.grfx_green, req_ch.grfx_blue} <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_table_path();
      test_error_status();
      test_empty_mask();
      test_overlay();
      test_ofm_fill();
      test_backpressure();
      test_random_mix();
      test_streaming();
      req_ch.valid <= 1'b0;
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d accesses and checked %0d results", accesses_sent, results_checked);
      $display("pixels: %0d through the tables, %0d from the overlay", table_pixels,
               overlay_pixels);
      if (failures == 0) begin
         $display("PASS colormap_lut_palette_core");
      end else begin
         $display("%0d failures", failures);
         $display("FAIL colormap_lut_palette_core");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL colormap_lut_palette_core");
      $finish;
   end

endmodule

FILE: filelist.f
sv/clp_pkg.sv
sv/clp_req_if.sv
sv/clp_rsp_if.sv
sv/clp_lut_stage.sv
sv/clp_ofm_stage.sv
sv/clp_out_fifo.sv
sv/colormap_lut_palette_core.sv
tb/tb_colormap_lut_palette_core.sv
